// ===== sv/rau_pkg.sv =====
// shared widths and operation codes for the rational arithmetic unit
package rau_pkg;

    localparam int IN_W       = 31;
    localparam int RES_W      = 63;
    localparam int OP_W_DEF   = 31;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_SUB = 2'd1;
    localparam logic [1:0] REQ_MUL = 2'd2;
    localparam logic [1:0] REQ_DIV = 2'd3;

endpackage

// ===== sv/rau_reduce.sv =====
// fraction reduction: binary gcd then two bit-serial exact divisions
module rau_reduce #(
    parameter int MW = 2 * rau_pkg::OP_W_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic signed [MW:0]   n_in,
    input  logic signed [MW:0]   d_in,
    output logic                 done,
    output logic signed [MW:0]   n_out,
    output logic signed [MW:0]   d_out
);
    import rau_pkg::*;

    localparam int VW = MW + 1;
    localparam int KW = $clog2(MW + 1);
    localparam int CW = $clog2(MW);

    typedef enum logic [2:0] {
        S_IDLE, S_EVEN, S_UODD, S_LOOP, S_GSH, S_DIVN, S_DIVD
    } state_t;

    state_t              state_reg;
    logic [MW-1:0]       u_reg, v_reg, nmag_reg, dmag_reg, g_reg, x_reg, rem_reg;
    logic [KW-1:0]       k_reg;
    logic [CW-1:0]       cnt_reg;
    logic                nneg_reg, dneg_reg, done_reg;
    logic signed [VW-1:0] n_out_reg, d_out_reg;

    logic [MW-1:0]       n_mag, d_mag;
    logic [MW:0]         trial, diff;
    logic                ge;
    logic [MW-1:0]       rem_next, x_next;
    logic [VW-1:0]       q_pos, q_neg;

    // magnitudes of the incoming pair
    always_comb
    begin
        n_mag = n_in[VW-1] ? MW'(-n_in) : n_in[MW-1:0];
        d_mag = d_in[VW-1] ? MW'(-d_in) : d_in[MW-1:0];
    end

    // one restoring division step; quotient bits shift into x
    always_comb
    begin
        trial    = {rem_reg, x_reg[MW-1]};
        diff     = trial - {1'b0, g_reg};
        ge       = (trial >= {1'b0, g_reg});
        rem_next = ge ? diff[MW-1:0] : trial[MW-1:0];
        x_next   = {x_reg[MW-2:0], ge};
        q_pos    = {1'b0, x_next};
        q_neg    = -q_pos;
    end

    // sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        if (n_in == '0)
                        begin
                            n_out_reg <= '0;
                            d_out_reg <= VW'(1);
                            done_reg  <= 1'b1;
                        end
                        else
                        begin
                            nmag_reg  <= n_mag;
                            dmag_reg  <= d_mag;
                            u_reg     <= n_mag;
                            v_reg     <= d_mag;
                            nneg_reg  <= n_in[VW-1];
                            dneg_reg  <= d_in[VW-1];
                            k_reg     <= '0;
                            state_reg <= S_EVEN;
                        end
                    end
                end
                S_EVEN:
                begin
                    if ((u_reg[0] | v_reg[0]) == 1'b0)
                    begin
                        u_reg <= u_reg >> 1;
                        v_reg <= v_reg >> 1;
                        k_reg <= k_reg + KW'(1);
                    end
                    else
                        state_reg <= S_UODD;
                end
                S_UODD:
                begin
                    if (!u_reg[0])
                        u_reg <= u_reg >> 1;
                    else
                        state_reg <= S_LOOP;
                end
                S_LOOP:
                begin
                    if (v_reg == '0)
                        state_reg <= S_GSH;
                    else if (!v_reg[0])
                        v_reg <= v_reg >> 1;
                    else if (u_reg > v_reg)
                    begin
                        u_reg <= v_reg;
                        v_reg <= u_reg - v_reg;
                    end
                    else
                        v_reg <= v_reg - u_reg;
                end
                S_GSH:
                begin
                    g_reg     <= u_reg << k_reg;
                    x_reg     <= nmag_reg;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= S_DIVN;
                end
                S_DIVN:
                begin
                    rem_reg <= rem_next;
                    x_reg   <= x_next;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(MW - 1))
                    begin
                        n_out_reg <= nneg_reg ? q_neg : q_pos;
                        x_reg     <= dmag_reg;
                        rem_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIVD;
                    end
                end
                S_DIVD:
                begin
                    rem_reg <= rem_next;
                    x_reg   <= x_next;
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(MW - 1))
                    begin
                        d_out_reg <= dneg_reg ? q_neg : q_pos;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign n_out = n_out_reg;
    assign d_out = d_out_reg;

endmodule

// ===== sv/rational_arithmetic_unit.sv =====
// top level: fraction add/subtract/multiply/divide with reduction to lowest terms
//
// Raise start for a beat while busy is low; the operands are taken then and
// busy stays high until the result shows. The result appears on res_num,
// res_den and div_zero for exactly one cycle with done high, and the receiver
// cannot stall it. Each of the three reductions (first operand, second
// operand, result) runs a one-step-per-cycle binary gcd and then two
// restoring divisions of one bit per cycle by the gcd. A zero operand
// denominator is answered from the check state, before any reduction.
module rational_arithmetic_unit #(
    parameter int OPERAND_WIDTH = rau_pkg::OP_W_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        req_type,
    input  logic signed [rau_pkg::IN_W-1:0]   a_num,
    input  logic signed [rau_pkg::IN_W-1:0]   a_den,
    input  logic signed [rau_pkg::IN_W-1:0]   b_num,
    input  logic signed [rau_pkg::IN_W-1:0]   b_den,
    output logic                              done,
    output logic signed [rau_pkg::RES_W-1:0]  res_num,
    output logic signed [rau_pkg::RES_W-1:0]  res_den,
    output logic                              div_zero
);
    import rau_pkg::*;

    localparam int OW = OPERAND_WIDTH;
    localparam int MW = 2 * OW;
    localparam int VW = MW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_RED_A, S_RED_B, S_MUL1, S_MUL2, S_MUL3, S_COMB, S_RED_R
    } state_t;

    state_t               state_reg;
    logic [1:0]           req_reg;
    logic signed [OW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [VW-1:0] p1_reg, p2_reg, p3_reg;
    logic signed [VW-1:0] red_n_reg, red_d_reg;
    logic                 go_reg, done_reg, dz_reg;
    logic signed [RES_W-1:0] res_num_reg, res_den_reg;

    logic                 red_done;
    logic signed [VW-1:0] red_n_out, red_d_out;
    logic signed [OW-1:0] ma, mb;
    logic signed [MW-1:0] prod;
    logic signed [VW-1:0] prod_x, rn, rd;

    rau_reduce #(.MW(MW)) u_reduce (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (go_reg),
        .n_in  (red_n_reg),
        .d_in  (red_d_reg),
        .done  (red_done),
        .n_out (red_n_out),
        .d_out (red_d_out)
    );

    // shared multiplier operand select
    always_comb
    begin
        ma = ad_reg;
        mb = bd_reg;
        case (state_reg)
            S_MUL1:
            begin
                ma = an_reg;
                mb = (req_reg == REQ_MUL) ? bn_reg : bd_reg;
            end
            S_MUL2:
            begin
                ma = ad_reg;
                mb = bn_reg;
            end
            default:
            begin
                ma = ad_reg;
                mb = bd_reg;
            end
        endcase
        prod   = ma * mb;
        prod_x = VW'(prod);
    end

    // cross-product combine
    always_comb
    begin
        case (req_reg)
            REQ_ADD: rn = p1_reg + p2_reg;
            REQ_SUB: rn = p1_reg - p2_reg;
            default: rn = p1_reg;
        endcase
        rd = (req_reg == REQ_DIV) ? p2_reg : p3_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            go_reg   <= 1'b0;
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        req_reg   <= req_type;
                        an_reg    <= a_num[OW-1:0];
                        ad_reg    <= a_den[OW-1:0];
                        bn_reg    <= b_num[OW-1:0];
                        bd_reg    <= b_den[OW-1:0];
                        state_reg <= S_CHK;
                    end
                end
                S_CHK:
                begin
                    if (ad_reg == '0 || bd_reg == '0)
                    begin
                        res_num_reg <= '0;
                        res_den_reg <= '0;
                        dz_reg      <= 1'b1;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        red_n_reg <= VW'(an_reg);
                        red_d_reg <= VW'(ad_reg);
                        go_reg    <= 1'b1;
                        state_reg <= S_RED_A;
                    end
                end
                S_RED_A:
                begin
                    if (red_done)
                    begin
                        an_reg    <= red_n_out[OW-1:0];
                        ad_reg    <= red_d_out[OW-1:0];
                        red_n_reg <= VW'(bn_reg);
                        red_d_reg <= VW'(bd_reg);
                        go_reg    <= 1'b1;
                        state_reg <= S_RED_B;
                    end
                end
                S_RED_B:
                begin
                    if (red_done)
                    begin
                        bn_reg    <= red_n_out[OW-1:0];
                        bd_reg    <= red_d_out[OW-1:0];
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    p1_reg    <= prod_x;
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    p2_reg    <= prod_x;
                    state_reg <= S_MUL3;
                end
                S_MUL3:
                begin
                    p3_reg    <= prod_x;
                    state_reg <= S_COMB;
                end
                S_COMB:
                begin
                    if (rd == '0)
                    begin
                        res_num_reg <= '0;
                        res_den_reg <= '0;
                        dz_reg      <= 1'b1;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else
                    begin
                        red_n_reg <= rn;
                        red_d_reg <= rd;
                        go_reg    <= 1'b1;
                        state_reg <= S_RED_R;
                    end
                end
                S_RED_R:
                begin
                    if (red_done)
                    begin
                        res_num_reg <= RES_W'(red_n_out);
                        res_den_reg <= RES_W'(red_d_out);
                        dz_reg      <= 1'b0;
                        done_reg    <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = done_reg;
    assign res_num  = res_num_reg;
    assign res_den  = res_den_reg;
    assign div_zero = dz_reg;

endmodule

// ===== sv/rau_checker.sv =====
// port-level checks for the rational arithmetic unit, bound to the top level
module rau_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic signed [rau_pkg::RES_W-1:0]  res_num,
    input logic signed [rau_pkg::RES_W-1:0]  res_den,
    input logic                              div_zero
);
    import rau_pkg::*;

    // an accepted beat makes the block busy with no result yet
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accept did not raise busy");

    // a result beat closes a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result beat outside a busy period");

    // error results carry zeros
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_zero |-> res_num == '0 && res_den == '0)
        else $error("error result not zeroed");

    // a good result never has a zero denominator
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !div_zero |-> res_den != '0)
        else $error("zero denominator without error");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// ===== sim/rational_arithmetic_unit_test.sv =====
// testbench for the rational arithmetic unit: directed and random fraction beats
module rational_arithmetic_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rau_pkg::*;

    typedef struct packed {
        logic signed [RES_W-1:0] num;
        logic signed [RES_W-1:0] den;
        logic                    dz;
    } fraction_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              req_type;
    logic signed [IN_W-1:0]  a_num;
    logic signed [IN_W-1:0]  a_den;
    logic signed [IN_W-1:0]  b_num;
    logic signed [IN_W-1:0]  b_den;
    logic                    done;
    logic signed [RES_W-1:0] res_num;
    logic signed [RES_W-1:0] res_den;
    logic                    div_zero;

    fraction_t pending_results[$];
    int        error_count;
    int        cycle_count;
    int        burst_left;

    localparam int MAX_CYCLES = 12_000_000;
    localparam logic signed [IN_W-1:0] OP_MAX = IN_W'((1 <<< (IN_W - 1)) - 1);
    localparam logic signed [IN_W-1:0] OP_MIN = IN_W'(-(1 <<< (IN_W - 1)));

    rational_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .a_num(a_num), .a_den(a_den),
        .b_num(b_num), .b_den(b_den), .done(done),
        .res_num(res_num), .res_den(res_den), .div_zero(div_zero)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("rational_arithmetic_unit test failed");
            $finish;
        end
    end

    function automatic logic [63:0] magnitude(logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    // stein gcd on nonzero magnitudes
    function automatic logic [63:0] stein_gcd(logic [63:0] u, logic [63:0] v);
        int          shift;
        logic [63:0] t;
        shift = 0;
        while (((u | v) & 1) == 0)
        begin
            u = u >> 1;
            v = v >> 1;
            shift++;
        end
        while ((u & 1) == 0)
            u = u >> 1;
        while (v != 0)
        begin
            while ((v & 1) == 0)
                v = v >> 1;
            if (u > v)
            begin
                t = u;
                u = v;
                v = t;
            end
            v = v - u;
        end
        return u << shift;
    endfunction

    // reduce n/d to lowest terms, d nonzero
    function automatic void lowest_terms(inout logic signed [63:0] n,
            inout logic signed [63:0] d);
        logic [63:0] g;
        logic [63:0] q;
        if (n == 0)
        begin
            d = 1;
        end
        else
        begin
            g = stein_gcd(magnitude(n), magnitude(d));
            q = magnitude(n) / g;
            n = n < 0 ? -$signed(q) : $signed(q);
            q = magnitude(d) / g;
            d = d < 0 ? -$signed(q) : $signed(q);
        end
    endfunction

    function automatic fraction_t fraction_result(logic [1:0] op,
            logic signed [IN_W-1:0] an_i, logic signed [IN_W-1:0] ad_i,
            logic signed [IN_W-1:0] bn_i, logic signed [IN_W-1:0] bd_i);
        logic signed [63:0] an, ad, bn, bd, rn, rd;
        fraction_t          r;
        an = an_i;
        ad = ad_i;
        bn = bn_i;
        bd = bd_i;
        r  = '0;
        if (ad == 0 || bd == 0)
        begin
            r.dz = 1'b1;
            return r;
        end
        lowest_terms(an, ad);
        lowest_terms(bn, bd);
        case (op)
            REQ_ADD: begin rn = an * bd + ad * bn; rd = ad * bd; end
            REQ_SUB: begin rn = an * bd - ad * bn; rd = ad * bd; end
            REQ_MUL: begin rn = an * bn;           rd = ad * bd; end
            default: begin rn = an * bd;           rd = ad * bn; end
        endcase
        if (rd == 0)
        begin
            r.dz = 1'b1;
            return r;
        end
        lowest_terms(rn, rd);
        r.num = rn[RES_W-1:0];
        r.den = rd[RES_W-1:0];
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        fraction_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: %0d/%0d dz=%0d",
                         $time, res_num, res_den, div_zero);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_num !== want.num)
                begin
                    $display("%0t: res_num expected %0d actual %0d", $time, want.num, res_num);
                    error_count++;
                end
                if (res_den !== want.den)
                begin
                    $display("%0t: res_den expected %0d actual %0d", $time, want.den, res_den);
                    error_count++;
                end
                if (div_zero !== want.dz)
                begin
                    $display("%0t: div_zero expected %0d actual %0d", $time, want.dz, div_zero);
                    error_count++;
                end
            end
        end
    end

    // send one beat, with bursty gaps before it; start stays high inside a burst
    task automatic send_fraction(logic [1:0] op, logic signed [IN_W-1:0] an,
            logic signed [IN_W-1:0] ad, logic signed [IN_W-1:0] bn,
            logic signed [IN_W-1:0] bd);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        start    <= 1'b1;
        req_type <= op;
        a_num    <= an;
        a_den    <= ad;
        b_num    <= bn;
        b_den    <= bd;
        @(posedge clk);
        while (busy) @(posedge clk);
        pending_results.push_back(fraction_result(op, an, ad, bn, bd));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // random operand: mostly small, sometimes full width
    function automatic logic signed [IN_W-1:0] rand_operand();
        case ($urandom_range(0, 5))
            0:       return IN_W'($urandom);
            1:       return IN_W'($signed($urandom_range(0, 40)) - 20);
            2:       return IN_W'($signed($urandom_range(0, 2000)) - 1000);
            3:       return IN_W'(($urandom_range(0, 1) ? OP_MAX : OP_MIN)
                                  + $urandom_range(0, 3) - 0);
            default: return IN_W'($signed($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task automatic test_directed();
        send_fraction(REQ_ADD, 1, 2, 1, 3);
        send_fraction(REQ_SUB, 1, 2, 1, 2);
        send_fraction(REQ_MUL, -2, 4, 3, -9);
        send_fraction(REQ_DIV, 3, 4, 2, 5);
        send_fraction(REQ_ADD, 0, 7, 5, 10);
        send_fraction(REQ_DIV, 1, 2, 0, 5);
        send_fraction(REQ_MUL, 1, 0, 1, 1);
        send_fraction(REQ_SUB, 1, 1, 1, 0);
        send_fraction(REQ_ADD, OP_MAX, OP_MAX, OP_MAX, 1);
        send_fraction(REQ_MUL, OP_MIN, 1, OP_MIN, 1);
        send_fraction(REQ_DIV, OP_MIN, OP_MAX, OP_MAX, OP_MIN);
        send_fraction(REQ_SUB, OP_MIN, -1, OP_MAX, -1);
        send_fraction(REQ_ADD, -1, -1, -1, -1);
        send_fraction(REQ_MUL, 0, -5, 0, OP_MIN);
        send_fraction(REQ_DIV, OP_MAX, 3, OP_MIN, 7);
        send_fraction(REQ_ADD, 1024, 4096, 12, 48);
        send_fraction(REQ_SUB, 6, 1, 6, 1);
        send_fraction(REQ_DIV, -5, 1, 0, -3);
    endtask

    task automatic test_random(int count);
        logic signed [IN_W-1:0] an, ad, bn, bd;
        for (int i = 0; i < count; i++)
        begin
            an = rand_operand();
            ad = rand_operand();
            bn = rand_operand();
            bd = rand_operand();
            if ($urandom_range(0, 30) == 0) ad = 0;
            if ($urandom_range(0, 30) == 0) bn = 0;
            if ($urandom_range(0, 40) == 0) an = 0;
            send_fraction(2'($urandom_range(0, 3)), an, ad, bn, bd);
        end
    endtask

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        burst_left  = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = REQ_ADD;
        a_num       = '0;
        a_den       = 1;
        b_num       = '0;
        b_den       = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        // hold off until everything has drained
        wait_drained();
        test_random(1930);
        wait_drained();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("rational_arithmetic_unit test passed");
        else
            $display("rational_arithmetic_unit test failed");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/rau_pkg.sv
sv/rau_reduce.sv
sv/rational_arithmetic_unit.sv
sv/rau_checker.sv
sim/rational_arithmetic_unit_test.sv
